// ===== src/assert_macros.svh =====
// Assertion helpers used by aes_cbc_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ===== src/aes_cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// Shared types, command codes and AES byte functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes_cbc_pkg;
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_ROUND = 2'd2;
	localparam logic [1:0] CMD_LASTR = 2'd3;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] round;
		logic       key_start;
		logic       key_step;
		logic       out_load;
	} aes_cbc_cmd_t;

	typedef struct packed {
		logic key_busy;
		logic out_full;
	} aes_cbc_sts_t;

	function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction
endpackage

// ===== src/aes_cbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_ctrl
// Sequencer: key expansion, round count and output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_cbc_ctrl
	import aes_cbc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr,
	input  logic         in_fire,
	input  aes_cbc_sts_t sts,
	output logic         busy,
	output aes_cbc_cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_KEY  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [3:0] rnd_q;
	logic       kreq_q;

	assign busy = (state_q != ST_IDLE) || kreq_q;

	always_comb begin
		cmd = '0;
		cmd.round = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) cmd.op = CMD_LOAD;
				if (kreq_q) cmd.key_start = 1'b1;
			end
			ST_KEY:  cmd.key_step = 1'b1;
			ST_RUN:  cmd.op = (rnd_q == 4'd0) ? CMD_LASTR : CMD_ROUND;
			ST_DONE: cmd.out_load = !sts.out_full;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= 4'd0;
			kreq_q  <= 1'b1;
		end else begin
			if (cfg_wr) kreq_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (kreq_q && !cfg_wr) begin
						kreq_q  <= 1'b0;
						state_q <= ST_KEY;
					end else if (in_fire) begin
						rnd_q   <= 4'd9;
						state_q <= ST_RUN;
					end
				end
				ST_KEY:  if (!sts.key_busy) state_q <= ST_IDLE;
				ST_RUN: begin
					if (rnd_q == 4'd0) state_q <= ST_DONE;
					else rnd_q <= rnd_q - 4'd1;
				end
				ST_DONE: if (!sts.out_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_run_round, clk, arst_n, state_q == ST_RUN, rnd_q <= 4'd9)
	`ASSERT_NEXT(a_last_done, clk, arst_n, state_q == ST_RUN && rnd_q == 4'd0, state_q == ST_DONE)
	`ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.op == CMD_LOAD, state_q == ST_IDLE && !kreq_q)
endmodule

// ===== src/aes_cbc_dp.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_dp
// Datapath: key schedule, round keys, state, CBC chain and pad check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_cbc_dp
	import aes_cbc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  aes_cbc_cmd_t cmd,
	output aes_cbc_sts_t sts,
	input  logic [63:0]  key_high,
	input  logic [63:0]  key_low,
	input  logic [127:0] cin,
	input  logic         first_in,
	input  logic         last_in,
	input  logic         out_take,
	output logic [127:0] pout,
	output logic         out_last,
	output logic [4:0]   out_pad,
	output logic         out_err
);
	logic [127:0] rk_q [11];
	logic [127:0] kw_q;
	logic [3:0]   kidx_q;
	logic [127:0] st_q, prev_q, civ_q, cin_q;
	logic         last_q, full_q;
	logic [127:0] knext, ss, rk_sel, ak, mx, dec, pt;
	logic [31:0]  tw;
	logic [4:0]   plen;
	logic         perr;

	always_comb begin
		tw = {fwd_sbox(kw_q[23:16]) ^ rcon(kidx_q + 4'd1), fwd_sbox(kw_q[15:8]),
			fwd_sbox(kw_q[7:0]), fwd_sbox(kw_q[31:24])};
		knext[127:96] = kw_q[127:96] ^ tw;
		knext[95:64]  = kw_q[95:64] ^ knext[127:96];
		knext[63:32]  = kw_q[63:32] ^ knext[95:64];
		knext[31:0]   = kw_q[31:0] ^ knext[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kidx_q <= 4'd0;
		else if (cmd.key_start) kidx_q <= 4'd0;
		else if (cmd.key_step && kidx_q != 4'd10) kidx_q <= kidx_q + 4'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.key_start) begin
			kw_q     <= {key_high, key_low};
		end else if (cmd.key_step) begin
			rk_q[kidx_q] <= kw_q;
			kw_q <= knext;
		end
	end

	assign sts.key_busy = cmd.key_start || (kidx_q != 4'd10);

	// byte k of the block sits at bits [127-8k -: 8]
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				ss[127 - 8*(4*c+r) -: 8] = inv_sbox(st_q[127 - 8*(4*((c-r)&3)+r) -: 8]);
		rk_sel = rk_q[cmd.round];
		ak = ss ^ rk_sel;
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a [4];
			logic [7:0] m2 [4];
			logic [7:0] m4 [4];
			logic [7:0] m8 [4];
			for (int r = 0; r < 4; r++) begin
				a[r]  = ak[127 - 8*(4*c+r) -: 8];
				m2[r] = xtime(a[r]);
				m4[r] = xtime(m2[r]);
				m8[r] = xtime(m4[r]);
			end
			for (int r = 0; r < 4; r++)
				mx[127 - 8*(4*c+r) -: 8] = m8[r] ^ m4[r] ^ m2[r]
					^ m8[(r+1)&3] ^ m2[(r+1)&3] ^ a[(r+1)&3]
					^ m8[(r+2)&3] ^ m4[(r+2)&3] ^ a[(r+2)&3]
					^ m8[(r+3)&3] ^ a[(r+3)&3];
		end
		dec = ak ^ civ_q;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: begin
				st_q    <= cin ^ rk_q[10];
				civ_q   <= first_in ? 128'd0 : prev_q;
				cin_q   <= cin;
				last_q  <= last_in;
			end
			CMD_ROUND: st_q <= mx;
			CMD_LASTR: st_q <= dec;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prev_q <= '0;
		else if (cmd.op == CMD_LASTR) prev_q <= cin_q;
	end

	always_comb begin
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 16; i++)
			if (i < st_q[7:0] && st_q[8*i +: 8] != st_q[7:0]) ok = 1'b0;
		perr = 1'b0;
		plen = 5'd0;
		if (last_q) begin
			if (st_q[7:0] == 8'd0 || st_q[7:0] > 8'd16 || !ok) perr = 1'b1;
			else plen = st_q[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (cmd.out_load) full_q <= 1'b1;
		else if (out_take) full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pout     <= st_q;
			out_last <= last_q;
			out_pad  <= plen;
			out_err  <= perr;
		end
	end

	assign sts.out_full = full_q;
endmodule

// ===== src/aes128_cbc_decrypt_core.sv =====
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_core
// AES-128 CBC decryption with PKCS#7 pad check on the last block.
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | cipher_high, cipher_low, first_block, last_block
// out     | out_valid | out_stall | plain_high, plain_low, final_block, pad_length, pad_error
// One block runs as load with round-key-10 addition, then nine inverse
// rounds and a final round on one shared round unit, then a move into the output
// register. After reset and after each key write the schedule is rebuilt:
// a start step, then one round key per cycle. The output register
// frees the round unit: the next block is taken while a result waits under out_stall.
`timescale 1ns / 1ps
module aes128_cbc_decrypt_core
	import aes_cbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	input  logic        first_block,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] plain_high,
	output logic [63:0] plain_low,
	output logic        final_block,
	output logic [4:0]  pad_length,
	output logic        pad_error
);
	logic [63:0]  key_high_q, key_low_q;
	logic         busy, in_fire;
	aes_cbc_cmd_t cmd;
	aes_cbc_sts_t sts;
	logic [127:0] pout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_KEY_LOW) key_low_q <= cfg_data;
			else key_high_q <= cfg_data;
		end
	end

	assign in_stall = busy || cfg_we;
	assign in_fire  = in_valid && !in_stall;

	aes_cbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_we), .in_fire(in_fire),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	aes_cbc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.key_high(key_high_q), .key_low(key_low_q),
		.cin({cipher_high, cipher_low}), .first_in(first_block), .last_in(last_block),
		.out_take(out_valid && !out_stall), .pout(pout), .out_last(final_block),
		.out_pad(pad_length), .out_err(pad_error)
	);

	assign out_valid  = sts.out_full;
	assign plain_high = pout[127:64];
	assign plain_low  = pout[63:0];
endmodule
